// ----- hw/rtl/prt_pkg.sv -----
// Shared types and constants of the partition range table.
`default_nettype none

package prt_pkg;

   localparam int OP_W     = 2;
   localparam int DEV_W    = 16;
   localparam int BLK_W    = 48;
   localparam int KIND_W   = 3;
   localparam int ID_W     = 32;
   localparam int STATUS_W = 2;

   localparam int SLOTS_DEFAULT = 16;

   localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
   localparam logic [OP_W-1:0] OP_ADD    = 2'd1;
   localparam logic [OP_W-1:0] OP_DELETE = 2'd2;
   localparam logic [OP_W-1:0] OP_INFO   = 2'd3;

   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FAIL    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_OVERLAP = 2'd2;

   // Highest partition type that an add accepts.
   localparam logic [KIND_W-1:0] KIND_MAX = 3'd3;

   // One word of the slot memory.
   typedef struct packed {
      logic [ID_W-1:0]  id;
      logic [DEV_W-1:0] device;
      logic [BLK_W-1:0] start;
      logic [BLK_W-1:0] length;
   } slot_entry_type;

endpackage

`default_nettype wire

// ----- hw/rtl/prt_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module prt_ram #(
   parameter  int WIDTH  = 8,
   parameter  int DEPTH  = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [ADDR_W-1:0]        wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [ADDR_W-1:0]        rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/partition_range_table_top.sv -----
// Top level of the partition range table: sequencer, valid bits and slot memory.
`default_nettype none

// The partition range table keeps SLOTS partitions, each a device number, a start
// block and a block count, tagged by an id from a 32-bit counter.
// A transaction is issued by raising start with the req_ fields while busy is low;
// it is taken at that clock edge. Operation clear empties the table and enables it,
// add places a new range, delete frees the slot holding an id and info reads it back.
// Each transaction gives exactly one result, shown on the rsp_ ports for a single
// cycle with rsp_valid high. The receiver has no way to stall, so it must take the
// result in that cycle.
// Clear, and an add that fails its input checks, answer in the cycle after the
// transaction is taken, with busy staying low. The other operations walk the slot
// memory one slot per cycle through a single read port and one shared compare unit:
// add scans all SLOTS slots before it answers; delete and info stop at the first
// matching slot. Busy is high during the walk, so for those operations no new
// transaction is taken until the walk has ended.
// Reset empties the table at once and leaves it disabled until the first clear;
// the slot memory needs no clearing pass because a slot's contents are only used while it is valid.
module partition_range_table_top
   import prt_pkg::*;
#(
   parameter int SLOTS = SLOTS_DEFAULT
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output      logic                busy,
   input  wire logic [OP_W-1:0]     req_operation,
   input  wire logic [DEV_W-1:0]    req_device_id,
   input  wire logic [BLK_W-1:0]    req_range_start,
   input  wire logic [BLK_W-1:0]    req_range_length,
   input  wire logic [KIND_W-1:0]   req_kind,
   input  wire logic [ID_W-1:0]     req_target_id,
   output      logic                rsp_valid,
   output      logic [STATUS_W-1:0] rsp_status,
   output      logic [ID_W-1:0]     rsp_new_id,
   output      logic [DEV_W-1:0]    rsp_found_device,
   output      logic [BLK_W-1:0]    rsp_found_start,
   output      logic [BLK_W-1:0]    rsp_found_length
);

   localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W   = $clog2(SLOTS + 1);
   localparam int ENTRY_W = $bits(slot_entry_type);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;

   // Control state.
   logic [1:0]          state_ff,      state_in;
   logic [SLOTS-1:0]    valid_ff,      valid_in;
   logic [ID_W-1:0]     id_counter_ff, id_counter_in;
   logic                ready_ff,      ready_in;
   logic [CNT_W-1:0]    idx_ff,        idx_in;
   logic                chk_vld_ff,    chk_vld_in;
   logic                rsp_valid_ff,  rsp_valid_in;

   // Request and scan payload.
   logic [OP_W-1:0]     op_ff,         op_in;
   logic [DEV_W-1:0]    dev_ff,        dev_in;
   logic [BLK_W-1:0]    start_ff,      start_in;
   logic [BLK_W-1:0]    length_ff,     length_in;
   logic [BLK_W:0]      end_ff,        end_in;
   logic [ID_W-1:0]     target_ff,     target_in;
   logic [SLOT_W-1:0]   chk_idx_ff,    chk_idx_in;
   logic [SLOT_W-1:0]   sel_idx_ff,    sel_idx_in;
   logic                hit_ff,        hit_in;
   logic                free_ff,       free_in;

   // Result payload.
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [ID_W-1:0]     rsp_new_id_ff, rsp_new_id_in;
   logic [DEV_W-1:0]    rsp_dev_ff,    rsp_dev_in;
   logic [BLK_W-1:0]    rsp_start_ff,  rsp_start_in;
   logic [BLK_W-1:0]    rsp_length_ff, rsp_length_in;

   // Slot memory port.
   logic                ram_wr_en;
   logic                ram_rd_en;
   logic [SLOT_W-1:0]   ram_rd_addr;
   slot_entry_type      ram_wr_entry;
   logic [ENTRY_W-1:0]  ram_rd_data;
   slot_entry_type      entry;

   logic                issue;
   logic                last_slot;
   logic                slot_valid;
   logic [BLK_W:0]      slot_end;
   logic                overlap;
   logic [ID_W-1:0]     next_id;

   prt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (sel_idx_ff),
      .wr_data (ram_wr_entry),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign entry       = slot_entry_type'(ram_rd_data);
   assign issue       = (idx_ff < CNT_W'(SLOTS));
   assign ram_rd_addr = idx_ff[SLOT_W-1:0];
   assign last_slot   = (chk_idx_ff == SLOT_W'(SLOTS - 1));
   assign slot_valid  = valid_ff[chk_idx_ff];
   assign next_id     = id_counter_ff + ID_W'(1);

   // The shared compare unit: one 49-bit add, a device match and two range compares per slot. The
   // request's own end block is summed once when the transaction is taken.
   assign slot_end = {1'b0, entry.start} + {1'b0, entry.length};
   assign overlap  = (entry.device == dev_ff)
                   && ({1'b0, entry.start} < end_ff)
                   && ({1'b0, start_ff} < slot_end);

   always_comb begin
      ram_wr_entry.id     = next_id;
      ram_wr_entry.device = dev_ff;
      ram_wr_entry.start  = start_ff;
      ram_wr_entry.length = length_ff;
   end

   always_comb begin
      state_in      = state_ff;
      valid_in      = valid_ff;
      id_counter_in = id_counter_ff;
      ready_in      = ready_ff;
      idx_in        = idx_ff;
      chk_vld_in    = chk_vld_ff;
      rsp_valid_in  = 1'b0;
      op_in         = op_ff;
      dev_in        = dev_ff;
      start_in      = start_ff;
      length_in     = length_ff;
      end_in        = end_ff;
      target_in     = target_ff;
      chk_idx_in    = chk_idx_ff;
      sel_idx_in    = sel_idx_ff;
      hit_in        = hit_ff;
      free_in       = free_ff;
      rsp_status_in = rsp_status_ff;
      rsp_new_id_in = rsp_new_id_ff;
      rsp_dev_in    = rsp_dev_ff;
      rsp_start_in  = rsp_start_ff;
      rsp_length_in = rsp_length_ff;
      ram_wr_en     = 1'b0;
      ram_rd_en     = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in         = req_operation;
               dev_in        = req_device_id;
               start_in      = req_range_start;
               length_in     = req_range_length;
               end_in        = {1'b0, req_range_start} + {1'b0, req_range_length};
               target_in     = req_target_id;
               idx_in        = '0;
               chk_vld_in    = 1'b0;
               hit_in        = 1'b0;
               free_in       = 1'b0;
               rsp_status_in = STATUS_FAIL;
               rsp_new_id_in = '0;
               rsp_dev_in    = '0;
               rsp_start_in  = '0;
               rsp_length_in = '0;
               unique case (req_operation)
                  OP_CLEAR: begin
                     valid_in      = '0;
                     id_counter_in = '0;
                     ready_in      = 1'b1;
                     rsp_status_in = STATUS_OK;
                     rsp_valid_in  = 1'b1;
                  end
                  OP_ADD: begin
                     if (!ready_ff || (req_range_length == '0) || (req_kind > KIND_MAX)) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        state_in = ST_SCAN;
                     end
                  end
                  default: begin
                     state_in = ST_SCAN;
                  end
               endcase
            end
         end

         ST_SCAN: begin
            // Read slot idx while the slot read in the previous cycle is checked.
            chk_vld_in = issue;
            if (issue) begin
               ram_rd_en  = 1'b1;
               idx_in     = idx_ff + CNT_W'(1);
               chk_idx_in = idx_ff[SLOT_W-1:0];
            end
            if (chk_vld_ff) begin
               if (op_ff == OP_ADD) begin
                  if (slot_valid && overlap) begin
                     hit_in = 1'b1;
                  end
                  if (!slot_valid && !free_ff) begin
                     free_in    = 1'b1;
                     sel_idx_in = chk_idx_ff;
                  end
                  if (last_slot) begin
                     state_in = ST_FINISH;
                  end
               end else if (slot_valid && (entry.id == target_ff)) begin
                  // The lowest matching slot wins, so the walk ends here.
                  hit_in     = 1'b1;
                  sel_idx_in = chk_idx_ff;
                  state_in   = ST_FINISH;
                  if (op_ff == OP_INFO) begin
                     rsp_dev_in    = entry.device;
                     rsp_start_in  = entry.start;
                     rsp_length_in = entry.length;
                  end
               end else if (last_slot) begin
                  state_in = ST_FINISH;
               end
            end
         end

         ST_FINISH: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b1;
            case (op_ff)
               OP_ADD: begin
                  if (hit_ff) begin
                     rsp_status_in = STATUS_OVERLAP;
                  end else if (free_ff) begin
                     ram_wr_en            = 1'b1;
                     valid_in[sel_idx_ff] = 1'b1;
                     id_counter_in        = next_id;
                     rsp_new_id_in        = next_id;
                     rsp_status_in        = STATUS_OK;
                  end
               end
               OP_DELETE: begin
                  if (hit_ff) begin
                     valid_in[sel_idx_ff] = 1'b0;
                     rsp_status_in        = STATUS_OK;
                  end
               end
               OP_INFO: begin
                  if (hit_ff) begin
                     rsp_status_in = STATUS_OK;
                  end
               end
               default: begin
                  rsp_status_in = STATUS_FAIL;
               end
            endcase
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         valid_ff      <= '0;
         id_counter_ff <= '0;
         ready_ff      <= 1'b0;
         idx_ff        <= '0;
         chk_vld_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         valid_ff      <= valid_in;
         id_counter_ff <= id_counter_in;
         ready_ff      <= ready_in;
         idx_ff        <= idx_in;
         chk_vld_ff    <= chk_vld_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      dev_ff        <= dev_in;
      start_ff      <= start_in;
      length_ff     <= length_in;
      end_ff        <= end_in;
      target_ff     <= target_in;
      chk_idx_ff    <= chk_idx_in;
      sel_idx_ff    <= sel_idx_in;
      hit_ff        <= hit_in;
      free_ff       <= free_in;
      rsp_status_ff <= rsp_status_in;
      rsp_new_id_ff <= rsp_new_id_in;
      rsp_dev_ff    <= rsp_dev_in;
      rsp_start_ff  <= rsp_start_in;
      rsp_length_ff <= rsp_length_in;
   end

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_new_id       = rsp_new_id_ff;
   assign rsp_found_device = rsp_dev_ff;
   assign rsp_found_start  = rsp_start_ff;
   assign rsp_found_length = rsp_length_ff;

   // A taken transaction either answers at once or keeps the block busy.
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid))
      else $error("taken transaction neither answered nor started a scan");

   // Only an add can report an overlap.
   a_overlap_from_add: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == STATUS_OVERLAP)) |-> (op_ff == OP_ADD))
      else $error("overlap status for an operation other than add");

   // A successful add reports the id that the counter now holds.
   a_add_id: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == STATUS_OK) && (op_ff == OP_ADD))
         |-> (rsp_new_id == id_counter_ff))
      else $error("new id differs from the id counter");

endmodule

`default_nettype wire
